// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the feast date calculator.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent is checked in the same cycle as the antecedent.
`define EFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent is checked in the cycle after the antecedent.
`define EFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// Consequent is a sequence that carries its own delay.
`define EFD_ASSERT_SEQ(lbl, ante, seq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> seq) else $error(msg);

`endif

// ----- hw/rtl/efd_pkg.sv -----
// Shared types and constants for the feast date calculator.
// Used by efd_ctrl, efd_dp and easter_feast_dates; depends on nothing.
package efd_pkg;

	localparam int unsigned YEAR_W = 14;
	localparam int unsigned DOM_W  = 5;
	localparam int unsigned MON_W  = 3;
	localparam int unsigned CMON_W = 2;

	// Reciprocals for exact division by constants over the value ranges used.
	localparam logic [12:0] RECIP_100 = 13'd5243;  // shift 19
	localparam logic [14:0] RECIP_19  = 15'd27595; // shift 19
	localparam logic [5:0]  RECIP_25  = 6'd41;     // shift 10
	localparam logic [7:0]  RECIP_3   = 8'd171;    // shift 9
	localparam logic [9:0]  RECIP_30  = 10'd547;   // shift 14
	localparam logic [7:0]  RECIP_7   = 8'd147;    // shift 10

	localparam logic [8:0] MOON_LIMIT = 9'd451;

	localparam logic [MON_W-1:0]  MON_MARCH = 3'd3;
	localparam logic [MON_W-1:0]  MON_APRIL = 3'd4;
	localparam logic [MON_W-1:0]  MON_MAY   = 3'd5;
	localparam logic [MON_W-1:0]  MON_JUNE  = 3'd6;
	localparam logic [CMON_W-1:0] CMON_FEB  = 2'd2;
	localparam logic [CMON_W-1:0] CMON_MAR  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUOT,
		ST_SPLIT,
		ST_CENT,
		ST_EPACT,
		ST_WEEK,
		ST_OFFSET,
		ST_OUT
	} efd_state_t;

	typedef struct packed {
		logic ld_year;
		logic quot;
		logic split;
		logic cent;
		logic epact;
		logic week;
		logic offset;
		logic publish;
	} efd_cmd_t;

endpackage

// ----- hw/rtl/easter_feast_dates.sv -----
// Top level of the feast date calculator: sequencer, datapath and checks.
// Depends on efd_pkg, efd_ctrl, efd_dp and assert_macros.svh.
//
// A year is taken on a clock edge where start is high and busy is low. Done
// is registered from the last sequencer state and stays high for exactly one
// cycle. In that cycle the outputs carry the leap-year flag and the day and
// month of Easter, Carnival, Good Friday, Ascension and Whitsuntide. The
// receiver cannot stall, so the outputs must be captured in that cycle. After
// the year is loaded the sequencer walks seven datapath steps. The first five
// reduce the computus terms by divisions by constants, the sixth forms the
// Easter offset, and the last forms the dates. Busy drops in the cycle that
// done is high, so a new year can be started then. No new year is taken
// while busy is high, so one year is worked on at a time.
`include "assert_macros.svh"

module easter_feast_dates (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [efd_pkg::YEAR_W-1:0]         year_value,
	output logic                               busy,
	output logic                               done,
	output logic                               leap_flag,
	output logic [efd_pkg::DOM_W-1:0]          easter_dom,
	output logic [efd_pkg::MON_W-1:0]          easter_mon,
	output logic [efd_pkg::DOM_W-1:0]          carnival_dom,
	output logic [efd_pkg::CMON_W-1:0]         carnival_mon,
	output logic [efd_pkg::DOM_W-1:0]          friday_dom,
	output logic [efd_pkg::MON_W-1:0]          friday_mon,
	output logic [efd_pkg::DOM_W-1:0]          ascension_dom,
	output logic [efd_pkg::MON_W-1:0]          ascension_mon,
	output logic [efd_pkg::DOM_W-1:0]          pentecost_dom,
	output logic [efd_pkg::MON_W-1:0]          pentecost_mon
);

	efd_pkg::efd_cmd_t cmd;
	logic              accept;
	logic              months_ok;

	assign accept = start && !busy;

	assign months_ok = (easter_mon inside {efd_pkg::MON_MARCH, efd_pkg::MON_APRIL})
		&& (pentecost_mon inside {efd_pkg::MON_MAY, efd_pkg::MON_JUNE});

	efd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	efd_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.year_value    (year_value),
		.leap_flag     (leap_flag),
		.easter_dom    (easter_dom),
		.easter_mon    (easter_mon),
		.carnival_dom  (carnival_dom),
		.carnival_mon  (carnival_mon),
		.friday_dom    (friday_dom),
		.friday_mon    (friday_mon),
		.ascension_dom (ascension_dom),
		.ascension_mon (ascension_mon),
		.pentecost_dom (pentecost_dom),
		.pentecost_mon (pentecost_mon)
	);

	`EFD_ASSERT_NEXT(a_accept_busy, accept, busy, "Accepted year did not make the block busy")
	`EFD_ASSERT_SEQ(a_accept_done, accept, ##8 done, "Result not strobed eight cycles after start")
	`EFD_ASSERT_NOW(a_done_idle, done, !busy, "Result strobed while still busy")
	`EFD_ASSERT_NOW(a_done_months, done, months_ok, "Feast month out of range")

endmodule

// ----- hw/rtl/efd_ctrl.sv -----
// Sequencer for the feast date calculator: steps the datapath once per state.
// Depends on efd_pkg for the state type and the command struct.
module efd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output efd_pkg::efd_cmd_t cmd
);

	efd_pkg::efd_state_t state_q;
	efd_pkg::efd_state_t state_d;
	logic                done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			efd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = efd_pkg::ST_QUOT;
				end
			end
			efd_pkg::ST_QUOT:   state_d = efd_pkg::ST_SPLIT;
			efd_pkg::ST_SPLIT:  state_d = efd_pkg::ST_CENT;
			efd_pkg::ST_CENT:   state_d = efd_pkg::ST_EPACT;
			efd_pkg::ST_EPACT:  state_d = efd_pkg::ST_WEEK;
			efd_pkg::ST_WEEK:   state_d = efd_pkg::ST_OFFSET;
			efd_pkg::ST_OFFSET: state_d = efd_pkg::ST_OUT;
			efd_pkg::ST_OUT:    state_d = efd_pkg::ST_IDLE;
			default:            state_d = efd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			efd_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.ld_year = start;
			end
			efd_pkg::ST_QUOT:   cmd.quot    = 1'b1;
			efd_pkg::ST_SPLIT:  cmd.split   = 1'b1;
			efd_pkg::ST_CENT:   cmd.cent    = 1'b1;
			efd_pkg::ST_EPACT:  cmd.epact   = 1'b1;
			efd_pkg::ST_WEEK:   cmd.week    = 1'b1;
			efd_pkg::ST_OFFSET: cmd.offset  = 1'b1;
			efd_pkg::ST_OUT:    cmd.publish = 1'b1;
			default:            busy        = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efd_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == efd_pkg::ST_OUT);
		end
	end

	assign done = done_q;

endmodule

// ----- hw/rtl/efd_dp.sv -----
// Datapath of the feast date calculator: computus terms, Easter offset and
// the day and month of each feast. Depends on efd_pkg; driven by efd_ctrl.
module efd_dp (
	input  logic                               clk,
	input  efd_pkg::efd_cmd_t                  cmd,
	input  logic [efd_pkg::YEAR_W-1:0]         year_value,
	output logic                               leap_flag,
	output logic [efd_pkg::DOM_W-1:0]          easter_dom,
	output logic [efd_pkg::MON_W-1:0]          easter_mon,
	output logic [efd_pkg::DOM_W-1:0]          carnival_dom,
	output logic [efd_pkg::CMON_W-1:0]         carnival_mon,
	output logic [efd_pkg::DOM_W-1:0]          friday_dom,
	output logic [efd_pkg::MON_W-1:0]          friday_mon,
	output logic [efd_pkg::DOM_W-1:0]          ascension_dom,
	output logic [efd_pkg::MON_W-1:0]          ascension_mon,
	output logic [efd_pkg::DOM_W-1:0]          pentecost_dom,
	output logic [efd_pkg::MON_W-1:0]          pentecost_mon
);

	logic [efd_pkg::YEAR_W-1:0] y_q;
	logic [4:0] a_q;
	logic [7:0] b_q;
	logic [6:0] c_q;
	logic [5:0] d_q;
	logic [1:0] e_q;
	logic [2:0] f_q;
	logic [4:0] i_q;
	logic [1:0] k_q;
	logic       leap_q;
	logic [5:0] g_q;
	logic [4:0] h_q;
	logic [2:0] l_q;
	logic [5:0] r_q;

	logic [26:0] prod_b;
	logic [28:0] prod_a;
	logic [7:0]  quo_b;
	logic [9:0]  quo_a;
	logic [7:0]  f_arg;
	logic [12:0] prod_f;
	logic [7:0]  g_arg;
	logic [14:0] prod_g;
	logic [9:0]  t_val;
	logic [18:0] prod_h;
	logic [4:0]  quo_h;
	logic [6:0]  u_val;
	logic [13:0] prod_l;
	logic [3:0]  quo_l;
	logic [8:0]  v_val;
	logic [6:0]  r_val;
	logic [6:0]  r_ext;

	assign prod_b = 27'(y_q) * 27'(efd_pkg::RECIP_100);
	assign quo_b  = prod_b[26:19];
	assign prod_a = 29'(y_q) * 29'(efd_pkg::RECIP_19);
	assign quo_a  = prod_a[28:19];

	assign f_arg  = b_q + 8'd8;
	assign prod_f = 13'(f_arg) * 13'(efd_pkg::RECIP_25);

	assign g_arg  = b_q - 8'(f_q) + 8'd1;
	assign prod_g = 15'(g_arg) * 15'(efd_pkg::RECIP_3);

	assign t_val  = 10'd19 * 10'(a_q) + 10'(b_q) - 10'(d_q) - 10'(g_q) + 10'd15;
	assign prod_h = 19'(t_val) * 19'(efd_pkg::RECIP_30);
	assign quo_h  = prod_h[18:14];

	assign u_val  = 7'd32 + {4'd0, e_q, 1'b0} + {1'b0, i_q, 1'b0} - 7'(h_q) - 7'(k_q);
	assign prod_l = 14'(u_val) * 14'(efd_pkg::RECIP_7);
	assign quo_l  = prod_l[13:10];

	assign v_val  = 9'(a_q) + 9'd11 * 9'(h_q) + 9'd22 * 9'(l_q);
	assign r_val  = 7'(h_q) + 7'(l_q) + 7'd22
		- ((v_val >= efd_pkg::MOON_LIMIT) ? 7'd7 : 7'd0);

	assign r_ext  = 7'(r_q);

	always_ff @(posedge clk) begin
		if (cmd.ld_year) begin
			y_q <= year_value;
		end
		if (cmd.quot) begin
			b_q <= quo_b;
			c_q <= 7'(y_q - 14'(quo_b) * 14'd100);
			a_q <= 5'(y_q - 14'(quo_a) * 14'd19);
		end
		if (cmd.split) begin
			d_q    <= b_q[7:2];
			e_q    <= b_q[1:0];
			i_q    <= c_q[6:2];
			k_q    <= c_q[1:0];
			f_q    <= prod_f[12:10];
			leap_q <= (c_q == 7'd0) ? (b_q[1:0] == 2'd0) : (y_q[1:0] == 2'd0);
		end
		if (cmd.cent) begin
			g_q <= prod_g[14:9];
		end
		if (cmd.epact) begin
			h_q <= 5'(t_val - 10'(quo_h) * 10'd30);
		end
		if (cmd.week) begin
			l_q <= 3'(u_val - 7'(quo_l) * 7'd7);
		end
		if (cmd.offset) begin
			r_q <= r_val[5:0];
		end
		if (cmd.publish) begin
			leap_flag <= leap_q;
			if (r_ext > 7'd31) begin
				easter_mon <= efd_pkg::MON_APRIL;
				easter_dom <= 5'(r_ext - 7'd31);
			end else begin
				easter_mon <= efd_pkg::MON_MARCH;
				easter_dom <= 5'(r_ext);
			end
			if (r_ext > 7'd49) begin
				carnival_mon <= efd_pkg::CMON_MAR;
				carnival_dom <= 5'(r_ext - 7'd49);
			end else begin
				carnival_mon <= efd_pkg::CMON_FEB;
				carnival_dom <= 5'(r_ext - 7'd21 + 7'(leap_q));
			end
			if (r_ext > 7'd33) begin
				friday_mon <= efd_pkg::MON_APRIL;
				friday_dom <= 5'(r_ext - 7'd33);
			end else begin
				friday_mon <= efd_pkg::MON_MARCH;
				friday_dom <= 5'(r_ext - 7'd2);
			end
			if (r_ext <= 7'd22) begin
				ascension_mon <= efd_pkg::MON_APRIL;
				ascension_dom <= 5'(r_ext + 7'd8);
			end else if (r_ext <= 7'd53) begin
				ascension_mon <= efd_pkg::MON_MAY;
				ascension_dom <= 5'(r_ext - 7'd22);
			end else begin
				ascension_mon <= efd_pkg::MON_JUNE;
				ascension_dom <= 5'(r_ext - 7'd53);
			end
			if (r_ext <= 7'd43) begin
				pentecost_mon <= efd_pkg::MON_MAY;
				pentecost_dom <= 5'(r_ext - 7'd12);
			end else begin
				pentecost_mon <= efd_pkg::MON_JUNE;
				pentecost_dom <= 5'(r_ext - 7'd43);
			end
		end
	end

endmodule
